### hw/rtl/crit_pkg.sv
package crit_pkg;

	// Shared multiplier
	localparam int MUL_W  = 32;
	localparam int PROD_W = 2 * MUL_W;

	// Evaporation divider: capacity is below 2^19 and the quotient below 2^16
	localparam int CAP_W      = 19;
	localparam int QUO_W      = 16;
	localparam int DIVIDEND_W = CAP_W + QUO_W;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_LAI_MIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTINCTION = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEAF_STORE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEM_STORE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_STEM_FRAC  = 3'd4;

	localparam logic [15:0] LAI_MIN_RST    = 16'd0;
	localparam logic [14:0] EXTINCTION_RST = 15'd8192;
	localparam logic [13:0] LEAF_STORE_RST = 14'd819;
	localparam logic [13:0] STEM_STORE_RST = 14'd0;
	localparam logic [15:0] STEM_FRAC_RST  = 16'd0;

	// Reciprocals for the exact division of y^3 by 6 and y^4 by 24
	localparam logic [MUL_W-1:0] DIV6_RECIP  = 32'd2796203;
	localparam logic [MUL_W-1:0] DIV24_RECIP = 32'd699051;

	// Number of squarings that undo the scaling of the exponent by 1/256
	localparam int SQ_STEPS = 8;

	localparam logic [30:0] E_ONE = 31'h4000_0000;
	localparam logic [16:0] Q16_ONE = 17'h1_0000;

	function automatic logic [23:0] sat24(input logic [25:0] v);
		logic [23:0] r;
		r = (v[25:24] != 2'b00) ? 24'hFF_FFFF : v[23:0];
		return r;
	endfunction

endpackage

### hw/rtl/crit_mul.sv
module crit_mul (
	input  logic                       clk,
	input  logic                       en,
	input  logic [crit_pkg::MUL_W-1:0]  a,
	input  logic [crit_pkg::MUL_W-1:0]  b,
	output logic [crit_pkg::PROD_W-1:0] prod
);
	import crit_pkg::*;

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= {{MUL_W{1'b0}}, a} * {{MUL_W{1'b0}}, b};
		end
	end

	assign prod = prod_q;

endmodule

### hw/rtl/crit_div.sv
module crit_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [crit_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [crit_pkg::CAP_W-1:0]      divisor,
	output logic                            done,
	output logic [crit_pkg::QUO_W-1:0]      quotient
);
	import crit_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CAP_W-1:0]    rem_q;
	logic [CAP_W-1:0]    dvs_q;
	logic [QUO_W-1:0]    sh_q;
	logic [CAP_W:0]      trial;
	logic [CAP_W:0]      diff;
	logic                ge;

	// The upper dividend bits are known to be below the divisor, so only
	// the quotient bits need a step each.
	assign trial = {rem_q, sh_q[QUO_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(QUO_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DIVIDEND_W-1:QUO_W];
			sh_q  <= dividend[QUO_W-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CAP_W-1:0] : trial[CAP_W-1:0];
			sh_q  <= {sh_q[QUO_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule

### hw/rtl/canopy_rain_interception_step_top.sv
// Words are taken one at a time: a new word is accepted only in the idle state,
// once the last result has been handed on. The evaporation may need the division
// by capacity, and a saturated cover skips the series and the squarings; the
// products share the single 32x32 multiplier, and the divider takes 16 steps.
// Reset: asynchronous and active low; the sequencer and configuration registers
// return to their reset values and the stored canopy water to zero.
module canopy_rain_interception_step_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [crit_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [crit_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [19:0]                         rain_amount,
	input  logic [15:0]                         free_evaporation,
	input  logic [15:0]                         leaf_area,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [19:0]                         free_rain,
	output logic [23:0]                         drip_drainage,
	output logic [23:0]                         trunk_flow,
	output logic [23:0]                         through_water,
	output logic [23:0]                         ground_water,
	output logic [23:0]                         canopy_water
);
	import crit_pkg::*;

	typedef enum logic [21:0] {
		S_IDLE  = 22'h00_0001,
		S_KX    = 22'h00_0002,
		S_Y     = 22'h00_0004,
		S_Y2    = 22'h00_0008,
		S_Y3    = 22'h00_0010,
		S_Y4    = 22'h00_0020,
		S_D6    = 22'h00_0040,
		S_D24   = 22'h00_0080,
		S_SQ    = 22'h00_0100,
		S_SQR   = 22'h00_0200,
		S_EXP   = 22'h00_0400,
		S_CAP   = 22'h00_0800,
		S_FREE  = 22'h00_1000,
		S_GROSS = 22'h00_2000,
		S_SUM   = 22'h00_4000,
		S_EV    = 22'h00_8000,
		S_DIVLD = 22'h01_0000,
		S_DIV   = 22'h02_0000,
		S_SUB   = 22'h04_0000,
		S_DRAIN = 22'h08_0000,
		S_STEM  = 22'h10_0000,
		S_OUT   = 22'h20_0000
	} state_t;

	localparam int SQ_CNT_W = $clog2(SQ_STEPS);

	state_t               state_q;
	logic [SQ_CNT_W-1:0]  cnt_q;

	// Configuration
	logic [15:0] lai_min_q;
	logic [14:0] k_q;
	logic [13:0] leaf_q;
	logic [13:0] stem_q;
	logic [15:0] frac_q;

	// Working registers
	logic [19:0] rain_q;
	logic [15:0] evap_q;
	logic [15:0] lai_q;
	logic [25:0] y_q;
	logic [21:0] y2_q;
	logic [17:0] y3_q;
	logic [13:0] y4_q;
	logic [15:0] t6_q;
	logic [30:0] e_q;
	logic [16:0] cover_q;
	logic [CAP_W-1:0] cap_q;
	logic [19:0] free_q;
	logic [24:0] gross_q;
	logic [24:0] ev_q;
	logic [24:0] drain_q;
	logic [23:0] stored_q;

	// Result word
	logic        result_valid_q;
	logic [19:0] free_rain_q;
	logic [23:0] drip_q;
	logic [23:0] trunk_q;
	logic [23:0] through_q;
	logic [23:0] ground_q;
	logic [23:0] canopy_q;

	// Shared multiplier and divider
	logic                mul_en;
	logic [MUL_W-1:0]    mul_a;
	logic [MUL_W-1:0]    mul_b;
	logic [PROD_W-1:0]   prod_q;
	logic                div_start;
	logic                div_done;
	logic [QUO_W-1:0]    div_quo;

	// Combinational helpers
	logic [15:0] lai_eff;
	logic [31:0] e_poly;
	logic [61:0] sq_rnd;
	logic [30:0] ex_rnd;
	logic [35:0] free_rnd;
	logic [31:0] g100;
	logic [24:0] ev_clamped;
	logic [24:0] stem_val;
	logic [25:0] soil;
	logic [25:0] thru;
	logic        accept;
	logic        out_free;

	assign accept   = item_valid && !item_stall;
	assign out_free = !result_valid_q || !result_stall;
	assign lai_eff  = (lai_q < lai_min_q) ? lai_min_q : lai_q;

	assign e_poly = {1'b0, E_ONE} - {6'b0, y_q} + {11'b0, y2_q[21:1]}
		- {16'b0, t6_q} + {22'b0, prod_q[33:24]};
	assign sq_rnd   = prod_q[61:0] + 62'h2000_0000;
	assign ex_rnd   = e_q + 31'h2000;
	assign free_rnd = prod_q[35:0] + 36'h8000;
	assign g100     = ({7'b0, gross_q} << 6) + ({7'b0, gross_q} << 5)
		+ ({7'b0, gross_q} << 2);
	assign ev_clamped = (ev_q > gross_q) ? gross_q : ev_q;
	assign stem_val   = prod_q[40:16];
	assign soil       = {1'b0, drain_q} + {6'b0, free_q};
	assign thru       = soil - {1'b0, stem_val};

	// Operand selection for the shared multiplier; each product is taken
	// up in the state that follows its issue.
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_KX: begin
				mul_a = MUL_W'(k_q);
				mul_b = MUL_W'(lai_eff);
			end
			S_Y: begin
				mul_a = MUL_W'(prod_q[29:4]);
				mul_b = MUL_W'(prod_q[29:4]);
			end
			S_Y2: begin
				mul_a = MUL_W'(prod_q[51:30]);
				mul_b = MUL_W'(y_q);
			end
			S_Y3: begin
				mul_a = MUL_W'(prod_q[47:30]);
				mul_b = MUL_W'(y_q);
			end
			S_Y4: begin
				mul_a = MUL_W'(y3_q);
				mul_b = DIV6_RECIP;
			end
			S_D6: begin
				mul_a = MUL_W'(y4_q);
				mul_b = DIV24_RECIP;
			end
			S_SQ: begin
				mul_a = MUL_W'(e_q);
				mul_b = MUL_W'(e_q);
			end
			S_CAP: begin
				mul_a = MUL_W'(leaf_q);
				mul_b = MUL_W'(lai_q);
			end
			S_FREE: begin
				mul_a = MUL_W'(rain_q);
				mul_b = MUL_W'(Q16_ONE - cover_q);
			end
			S_EV: begin
				mul_a = MUL_W'(evap_q);
				mul_b = MUL_W'(gross_q);
			end
			S_STEM: begin
				mul_a = MUL_W'(drain_q);
				mul_b = MUL_W'(frac_q);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	assign div_start = (state_q == S_DIVLD);

	crit_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod_q)
	);

	crit_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q[DIVIDEND_W-1:0]),
		.divisor  (cap_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Sequencer, configuration and stored water
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cnt_q          <= '0;
			result_valid_q <= 1'b0;
			stored_q       <= '0;
			lai_min_q      <= LAI_MIN_RST;
			k_q            <= EXTINCTION_RST;
			leaf_q         <= LEAF_STORE_RST;
			stem_q         <= STEM_STORE_RST;
			frac_q         <= STEM_FRAC_RST;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_LAI_MIN:    lai_min_q <= cfg_data;
					CFG_EXTINCTION: k_q       <= cfg_data[14:0];
					CFG_LEAF_STORE: leaf_q    <= cfg_data[13:0];
					CFG_STEM_STORE: stem_q    <= cfg_data[13:0];
					CFG_STEM_FRAC:  frac_q    <= cfg_data;
					default: ;
				endcase
			end

			if (state_q == S_OUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_KX;
					end
				end
				S_KX:  state_q <= S_Y;
				S_Y: begin
					// k*lai of 16 or more gives full cover.
					state_q <= prod_q[30] ? S_CAP : S_Y2;
				end
				S_Y2:  state_q <= S_Y3;
				S_Y3:  state_q <= S_Y4;
				S_Y4:  state_q <= S_D6;
				S_D6:  state_q <= S_D24;
				S_D24: begin
					cnt_q   <= '0;
					state_q <= S_SQ;
				end
				S_SQ:  state_q <= S_SQR;
				S_SQR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SQ_CNT_W'(SQ_STEPS - 1)) begin
						state_q <= S_EXP;
					end else begin
						state_q <= S_SQ;
					end
				end
				S_EXP:   state_q <= S_CAP;
				S_CAP:   state_q <= S_FREE;
				S_FREE:  state_q <= S_GROSS;
				S_GROSS: state_q <= S_SUM;
				S_SUM:   state_q <= S_EV;
				S_EV: begin
					if (g100 < 32'(cap_q) || gross_q >= 25'(cap_q)) begin
						state_q <= S_SUB;
					end else begin
						state_q <= S_DIVLD;
					end
				end
				S_DIVLD: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_SUB;
					end
				end
				S_SUB: state_q <= S_DRAIN;
				S_DRAIN: begin
					stored_q <= (gross_q > 25'(cap_q)) ? 24'(cap_q) : gross_q[23:0];
					state_q  <= S_STEM;
				end
				S_STEM: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Data path registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					rain_q <= rain_amount;
					evap_q <= free_evaporation;
					lai_q  <= leaf_area;
				end
			end
			S_Y: begin
				y_q <= prod_q[29:4];
				if (prod_q[30]) begin
					cover_q <= Q16_ONE;
				end
			end
			S_Y2:  y2_q <= prod_q[51:30];
			S_Y3:  y3_q <= prod_q[47:30];
			S_Y4:  y4_q <= prod_q[43:30];
			S_D6:  t6_q <= prod_q[39:24];
			S_D24: e_q  <= e_poly[30:0];
			S_SQR: e_q  <= sq_rnd[60:30];
			S_EXP: cover_q <= Q16_ONE - ex_rnd[30:14];
			S_FREE: cap_q <= CAP_W'(prod_q[29:12]) + CAP_W'(stem_q);
			S_GROSS: free_q <= free_rnd[35:16];
			S_SUM: gross_q <= {1'b0, stored_q} + 25'(rain_q - free_q);
			S_EV: begin
				// Almost dry canopy loses all its water; a full one the whole
				// free evaporation.
				if (g100 < 32'(cap_q)) begin
					ev_q <= gross_q;
				end else begin
					ev_q <= 25'(evap_q);
				end
			end
			S_DIV: begin
				if (div_done) begin
					ev_q <= 25'(div_quo);
				end
			end
			S_SUB: gross_q <= gross_q - ev_clamped;
			S_DRAIN: begin
				drain_q <= (gross_q > 25'(cap_q)) ? (gross_q - 25'(cap_q)) : '0;
			end
			S_OUT: begin
				if (out_free) begin
					free_rain_q <= free_q;
					drip_q      <= sat24({1'b0, drain_q});
					trunk_q     <= sat24({1'b0, stem_val});
					through_q   <= sat24(thru);
					ground_q    <= sat24(soil);
					canopy_q    <= stored_q;
				end
			end
			default: ;
		endcase
	end

	assign item_stall    = (state_q != S_IDLE);
	assign result_valid  = result_valid_q;
	assign free_rain     = free_rain_q;
	assign drip_drainage = drip_q;
	assign trunk_flow    = trunk_q;
	assign through_water = through_q;
	assign ground_water  = ground_q;
	assign canopy_water  = canopy_q;

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_KX)
		else $error("accepted word did not start the sequence");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside its wait state");

	a_exp_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQ |-> e_q <= E_ONE)
		else $error("exponential term above one");

	a_store_in_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STEM |-> stored_q <= 24'(cap_q))
		else $error("stored canopy water above capacity");
`endif

endmodule

### tb/tb_canopy_rain_interception_step_top.sv
module tb_canopy_rain_interception_step_top;

	import crit_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int IDLE_PCT      = 17;
	localparam int SETTLE_CYCLES = 64;
	localparam int LAI_FRAC_BITS = 12;

	// Indexes past the last register; the block must ignore writes to them.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [19:0] rain;
		logic [15:0] evap;
		logic [15:0] lai;
	} hour_t;

	typedef struct packed {
		logic [19:0] free_rain;
		logic [23:0] drip;
		logic [23:0] trunk;
		logic [23:0] through;
		logic [23:0] ground;
		logic [23:0] canopy;
	} water_split_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic [19:0] rain_amount = '0;
	logic [15:0] free_evaporation = '0;
	logic [15:0] leaf_area = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [19:0] free_rain;
	logic [23:0] drip_drainage;
	logic [23:0] trunk_flow;
	logic [23:0] through_water;
	logic [23:0] ground_water;
	logic [23:0] canopy_water;

	// Predictor copy of the registers and of the water held on the canopy.
	logic [15:0] lai_floor   = LAI_MIN_RST;
	logic [14:0] extinction  = EXTINCTION_RST;
	logic [13:0] leaf_hold   = LEAF_STORE_RST;
	logic [13:0] stem_hold   = STEM_STORE_RST;
	logic [15:0] trunk_share = STEM_FRAC_RST;
	logic [23:0] stored_water = '0;

	hour_t        hour_queue[$];
	water_split_t owed_splits[$];
	hour_t        on_offer;
	logic         idling_on = 1'b1;

	int cycle_count   = 0;
	int hours_sent    = 0;
	int splits_seen   = 0;
	int mismatches    = 0;
	int settings_used = 1;
	int dried_steps   = 0;
	int shared_steps  = 0;
	int drained_steps = 0;

	canopy_rain_interception_step_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.rain_amount(rain_amount),
		.free_evaporation(free_evaporation),
		.leaf_area(leaf_area),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.free_rain(free_rain),
		.drip_drainage(drip_drainage),
		.trunk_flow(trunk_flow),
		.through_water(through_water),
		.ground_water(ground_water),
		.canopy_water(canopy_water)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [23:0] clip24(input logic [63:0] v);
		return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
	endfunction

	// Canopy cover 1-exp(-k*lai) in Q1.16: the exponent is scaled down by 256,
	// expanded up to its fourth power and squared back up.
	function automatic logic [16:0] canopy_shade(input logic [14:0] k, input logic [15:0] lai);
		logic [63:0] x, y, y2, y3, y4, e, ex16;
		x = 64'(k) * 64'(lai);
		if (x >= (64'd16 << 26))
			return 17'h1_0000;
		y = x >> 4;
		y2 = (y * y) >> 30;
		y3 = (y2 * y) >> 30;
		y4 = (y3 * y) >> 30;
		e = (64'd1 << 30) - y + (y2 >> 1) - y3 / 64'd6 + y4 / 64'd24;
		for (int i = 0; i < SQ_STEPS; i++)
			e = (e * e + (64'd1 << 29)) >> 30;
		ex16 = (e + (64'd1 << 13)) >> 14;
		if (ex16 > 64'd65536)
			ex16 = 64'd65536;
		return 17'(64'd65536 - ex16);
	endfunction

	// One hourly step of the interception store; updates stored_water.
	function automatic water_split_t soak_canopy(input hour_t h);
		logic [15:0] lai_eff;
		logic [16:0] shade;
		logic [63:0] rain, cap, free_r, gross, evap, drain, stem, soil;
		water_split_t r;
		rain = 64'(h.rain);
		lai_eff = (h.lai < lai_floor) ? lai_floor : h.lai;
		shade = canopy_shade(extinction, lai_eff);
		// Capacity uses the leaf area as given, not the raised one.
		cap = ((64'(leaf_hold) * 64'(h.lai)) >> LAI_FRAC_BITS) + 64'(stem_hold);
		free_r = (rain * (64'd65536 - 64'(shade)) + 64'd32768) >> 16;
		if (free_r > rain)
			free_r = rain;
		gross = 64'(stored_water) + (rain - free_r);
		if (gross * 64'd100 < cap) begin
			evap = gross;
			dried_steps++;
		end else if (gross >= cap) begin
			evap = 64'(h.evap);
		end else begin
			evap = 64'(h.evap) * gross / cap;
			shared_steps++;
		end
		if (evap > gross)
			evap = gross;
		gross = gross - evap;
		drain = (gross > cap) ? gross - cap : 64'd0;
		if (drain != 0)
			drained_steps++;
		stored_water = clip24(gross - drain);
		stem = (drain * 64'(trunk_share)) >> 16;
		soil = free_r + drain;
		r.free_rain = free_r[19:0];
		r.drip = clip24(drain);
		r.trunk = clip24(stem);
		r.through = clip24(soil - stem);
		r.ground = clip24(soil);
		r.canopy = stored_water;
		return r;
	endfunction

	// Mostly dry spells and light showers, so that the store fills and drains
	// slowly, with occasional storms over the full range.
	function automatic hour_t draw_hour();
		hour_t h;
		int roll;
		roll = $urandom_range(99);
		if (roll < 20)
			h.rain = '0;
		else if (roll < 55)
			h.rain = 20'($urandom_range(8191));
		else if (roll < 85)
			h.rain = 20'($urandom_range(131071));
		else
			h.rain = 20'($urandom_range(1048575));
		roll = $urandom_range(99);
		if (roll < 50)
			h.evap = 16'($urandom_range(1023));
		else if (roll < 85)
			h.evap = 16'($urandom_range(8191));
		else
			h.evap = 16'($urandom_range(65535));
		roll = $urandom_range(99);
		if (roll < 10)
			h.lai = '0;
		else if (roll < 20)
			h.lai = 16'hFFFF;
		else
			h.lai = 16'($urandom_range(65535));
		return h;
	endfunction

	task automatic queue_hour(input logic [19:0] rain, input logic [15:0] evap,
			input logic [15:0] lai);
		hour_queue.push_back({rain, evap, lai});
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_LAI_MIN: lai_floor = data;
			CFG_EXTINCTION: extinction = data[14:0];
			CFG_LEAF_STORE: leaf_hold = data[13:0];
			CFG_STEM_STORE: stem_hold = data[13:0];
			CFG_STEM_FRAC: trunk_share = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic set_canopy(input logic [15:0] lai_min, input logic [15:0] k,
			input logic [15:0] leaf, input logic [15:0] stem, input logic [15:0] share);
		write_reg(CFG_LAI_MIN, lai_min);
		write_reg(CFG_EXTINCTION, k);
		write_reg(CFG_LEAF_STORE, leaf);
		write_reg(CFG_STEM_STORE, stem);
		write_reg(CFG_STEM_FRAC, share);
		write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LAST, CFG_SPARE_FIRST)),
			16'($urandom_range(65535)));
		settings_used++;
		@(negedge clk);
	endtask

	// Holds the sender back until every word in flight has come out.
	task automatic wait_settled();
		@(negedge clk);
		while (hour_queue.size() != 0 || item_valid || owed_splits.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++)
			hour_queue.push_back(draw_hour());
		wait_settled();
	endtask

	task automatic check_field(input string label, input logic [23:0] want, input logic [23:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Mismatch on result %0d, %s: expected %0d, got %0d",
					splits_seen, label, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				owed_splits.push_back(soak_canopy(on_offer));
				hours_sent++;
			end
			if (!item_valid || !item_stall) begin
				if (hour_queue.size() != 0 && !(idling_on && $urandom_range(99) < IDLE_PCT)) begin
					on_offer = hour_queue.pop_front();
					item_valid <= 1'b1;
					rain_amount <= on_offer.rain;
					free_evaporation <= on_offer.evap;
					leaf_area <= on_offer.lai;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		water_split_t want;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (owed_splits.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result word arrived with none outstanding: canopy %0d",
							canopy_water);
				end else begin
					want = owed_splits.pop_front();
					check_field("free_rain", 24'(want.free_rain), 24'(free_rain));
					check_field("drip_drainage", want.drip, drip_drainage);
					check_field("trunk_flow", want.trunk, trunk_flow);
					check_field("through_water", want.through, through_water);
					check_field("ground_water", want.ground, ground_water);
					check_field("canopy_water", want.canopy, canopy_water);
				end
				splits_seen++;
			end
			result_stall <= idling_on && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out with %0d words pending and %0d results owed",
				hour_queue.size(), owed_splits.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: zero capacity, full storms, evaporation above the
		// water held, the store nearly empty and the proportional share.
		queue_hour(20'd0, 16'd0, 16'd0);
		queue_hour(20'hFFFFF, 16'd0, 16'd0);
		queue_hour(20'hFFFFF, 16'd0, 16'hFFFF);
		queue_hour(20'd0, 16'hFFFF, 16'hFFFF);
		queue_hour(20'd100, 16'd0, 16'hFFFF);
		queue_hour(20'd6000, 16'd1000, 16'hFFFF);
		queue_hour(20'd6000, 16'd0, 16'hFFFF);
		queue_hour(20'd0, 16'd300, 16'hFFFF);
		queue_hour(20'd0, 16'hFFFF, 16'h8000);
		run_random(240);

		// Every register at its top value: the cover saturates and almost all
		// drainage runs down the trunk.
		set_canopy(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_hour(20'd0, 16'd0, 16'd0);
		queue_hour(20'hFFFFF, 16'hFFFF, 16'hFFFF);
		queue_hour(20'hFFFFF, 16'd0, 16'hFFFF);
		queue_hour(20'hFFFFF, 16'd0, 16'd0);
		queue_hour(20'd50, 16'd0, 16'hFFFF);
		queue_hour(20'd0, 16'hFFFF, 16'd0);
		run_random(240);

		// Everything at zero: no cover, no capacity, so the store left over
		// from the last setting drains at once.
		set_canopy(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		queue_hour(20'hFFFFF, 16'hFFFF, 16'hFFFF);
		queue_hour(20'd12345, 16'd0, 16'd4096);
		run_random(200);

		for (int p = 0; p < 4; p++) begin
			set_canopy((p == 3) ? 16'($urandom_range(65535)) : 16'($urandom_range(12287)),
				16'($urandom_range(65535)), 16'($urandom_range(65535)),
				16'($urandom_range(65535)), 16'($urandom_range(65535)));
			// The first random setting runs with both sides flat out.
			idling_on = (p != 0);
			run_random((p == 0) ? 300 : 290);
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Checked %0d results from %0d hourly words over %0d canopy settings.",
			splits_seen, hours_sent, settings_used);
		$display("Steps drained: %0d, dried out: %0d, evaporation shared: %0d; mismatches: %0d",
			drained_steps, dried_steps, shared_steps, mismatches);
		if (mismatches == 0 && owed_splits.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
